[rtl/bbd_pkg.sv]
// shared types, constants and colour interpolation for the bilinear bayer demosaicer
package bbd_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = 16;
   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int RSP_DEPTH    = 8;
   localparam int RSP_AW       = $clog2(RSP_DEPTH);

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // request kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // mosaic site codes, {row odd, column odd}
   localparam logic [1:0] SITE_GREEN_RED_ROW  = 2'b00;
   localparam logic [1:0] SITE_RED            = 2'b01;
   localparam logic [1:0] SITE_BLUE           = 2'b10;
   localparam logic [1:0] SITE_GREEN_BLUE_ROW = 2'b11;

   typedef logic [PIX_W-1:0] pix_type;

   // [column: left, mid, right][row: top, mid, bottom]
   typedef pix_type [2:0][2:0] win_type;

   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } taps_type;

   // item held between the line store read and the window update
   typedef struct packed {
      logic             valid;
      logic             drain;
      logic             first_row;
      logic             emit;
      logic             col_ge1;
      logic             col_is1;
      logic             col_last;
      logic             row_odd;
      logic             col_odd;
      logic             last_row;
      logic [COL_W-1:0] addr;
      pix_type          px;
   } s1_type;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
      logic    end_of_line;
      logic    end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic rsp_type interp(win_type w, logic row_odd, logic col_odd);
      logic [PIX_W+1:0] cross_sum;
      logic [PIX_W+1:0] diag;
      logic [PIX_W:0]   horiz;
      logic [PIX_W:0]   vert;
      rsp_type          res;
      cross_sum = (PIX_W+2)'(w[0][1]) + (PIX_W+2)'(w[2][1])
                + (PIX_W+2)'(w[1][0]) + (PIX_W+2)'(w[1][2]);
      diag  = (PIX_W+2)'(w[0][0]) + (PIX_W+2)'(w[2][0])
            + (PIX_W+2)'(w[0][2]) + (PIX_W+2)'(w[2][2]);
      horiz = (PIX_W+1)'(w[0][1]) + (PIX_W+1)'(w[2][1]);
      vert  = (PIX_W+1)'(w[1][0]) + (PIX_W+1)'(w[1][2]);
      res = '0;
      case ({row_odd, col_odd})
         SITE_RED: begin
            res.red   = w[1][1];
            res.green = cross_sum[PIX_W+1:2];
            res.blue  = diag[PIX_W+1:2];
         end
         SITE_BLUE: begin
            res.red   = diag[PIX_W+1:2];
            res.green = cross_sum[PIX_W+1:2];
            res.blue  = w[1][1];
         end
         SITE_GREEN_BLUE_ROW: begin
            res.red   = vert[PIX_W:1];
            res.green = w[1][1];
            res.blue  = horiz[PIX_W:1];
         end
         default: begin
            res.red   = horiz[PIX_W:1];
            res.green = w[1][1];
            res.blue  = vert[PIX_W:1];
         end
      endcase
      return res;
   endfunction

endpackage

[rtl/bbd_line_store.sv]
// two-row line store: one memory word per column holding the previous and older rows
module bbd_line_store (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [bbd_pkg::COL_W-1:0] rd_addr,
   input  bbd_pkg::s1_type      s1,
   output bbd_pkg::taps_type    taps
);
   import bbd_pkg::*;

   // word = {older row, previous row}
   logic [2*PIX_W-1:0] mem_ff [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;
   pix_type            prev_px;
   pix_type            older_px;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      // write-back in the cycle after the read; the same column is not read again
      // for at least two transfers, so no forwarding is needed
      if (s1.valid && !s1.drain) begin
         mem_ff[s1.addr] <= {prev_px, s1.px};
      end
   end

   assign prev_px  = rd_data_ff[PIX_W-1:0];
   assign older_px = rd_data_ff[2*PIX_W-1:PIX_W];

   always_comb begin
      taps.mid = prev_px;
      if (s1.drain) begin
         // bottom mirrors the row above the last one
         taps.top = older_px;
         taps.bot = older_px;
      end else begin
         taps.bot = s1.px;
         taps.top = s1.first_row ? s1.px : older_px;
      end
   end

endmodule

[rtl/bbd_window.sv]
// 3x3 window shift with edge mirroring and colour interpolation
module bbd_window (
   input  logic                clock,
   input  logic                reset,
   input  bbd_pkg::s1_type     s1,
   input  bbd_pkg::taps_type   taps,
   output bbd_pkg::push_type   push
);
   import bbd_pkg::*;

   win_type window_ff;
   win_type window_in;
   win_type w1;
   win_type w2;

   always_comb begin
      // shift in the new column
      w1[0] = window_ff[1];
      w1[1] = window_ff[2];
      w1[2] = {taps.bot, taps.mid, taps.top};
      // left edge mirror
      if (s1.col_is1) begin
         w1[0] = w1[2];
      end
      // right edge mirror
      w2[0] = w1[1];
      w2[1] = w1[2];
      w2[2] = w1[1];

      push.first  = interp(w1, s1.row_odd, s1.col_odd);
      push.second = interp(w2, s1.row_odd, ~s1.col_odd);
      push.second.end_of_line  = 1'b1;
      push.second.end_of_frame = s1.last_row;

      push.count = 2'd0;
      window_in  = window_ff;
      if (s1.valid && s1.emit) begin
         if (s1.col_ge1 && s1.col_last) begin
            push.count = 2'd2;
            window_in  = w2;
         end else begin
            push.count = s1.col_ge1 ? 2'd1 : 2'd0;
            window_in  = w1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

endmodule

[rtl/bbd_rsp_fifo.sv]
// result queue taking up to two results per cycle and giving one when not stalled
module bbd_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  bbd_pkg::push_type         push,
   input  logic                      pop_stall,
   output logic                      out_valid,
   output bbd_pkg::rsp_type          out_data,
   output logic [bbd_pkg::RSP_AW:0]  level
);
   import bbd_pkg::*;

   rsp_type           mem_ff [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff;
   logic [RSP_AW-1:0] wr_ptr_in;
   logic [RSP_AW-1:0] wr_next;
   logic [RSP_AW-1:0] rd_ptr_ff;
   logic [RSP_AW-1:0] rd_ptr_in;
   logic [RSP_AW:0]   level_ff;
   logic [RSP_AW:0]   level_in;
   logic              pop;

   assign out_valid = (level_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = out_valid && !pop_stall;
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_AW'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + (RSP_AW+1)'(push.count) - (RSP_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

[rtl/bayer_bilinear_demosaic.sv]
// top level of the streaming bilinear bayer demosaicer
//
// raw bayer samples come in on the req_ channel in raster order, one per transfer;
// req_type selects a pixel or a drain tick. rgb pixels leave on the rsp_ channel
// with end_of_line and end_of_frame flags. mosaic: red at even row / odd column,
// blue at odd row / even column, green elsewhere; borders mirror without repeat.
// output pixel (r,c) is produced by the transfer of input (r+1,c+1); the last
// input of a row also yields the last pixel of the row above, and after the
// frame's last sample, width drain transfers flush the final row.
// a result passes the s1 register and then the result queue before it is offered
// on rsp_valid; results ahead of it in the queue leave first.
// while req_stall is low the block takes one input per cycle: each transfer does one
// line store read and one write-back in the next cycle; a small result queue absorbs
// the two-result transfers at the right edge. req_stall rises only when that queue
// is nearly full, i.e. when the receiver holds rsp_stall; results wait in order, none
// are lost. reset (synchronous) empties the queue, clears the counters and window and
// loads 640 x 480; any csr write restarts the frame. the line store has no reset and
// needs no clearing pass: every entry is written before its data is used.
module bayer_bilinear_demosaic (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_en,
   input  logic [bbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]     csr_write_data,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [bbd_pkg::PIX_W-1:0]          req_raw_pixel,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bbd_pkg::PIX_W-1:0]          rsp_red,
   output logic [bbd_pkg::PIX_W-1:0]          rsp_green,
   output logic [bbd_pkg::PIX_W-1:0]          rsp_blue,
   output logic                               rsp_end_of_line,
   output logic                               rsp_end_of_frame
);
   import bbd_pkg::*;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [WIDTH_REG_W-1:0]  width_in;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [HEIGHT_REG_W-1:0] height_in;
   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_in;
   logic [COL_W-1:0]        col_ff;
   logic [COL_W-1:0]        col_in;
   s1_type                  s1_ff;
   s1_type                  s1_in;

   logic [COL_W-1:0]        w_m1;      // effective width minus one
   logic [ROW_W-1:0]        eff_h;
   logic [ROW_W-1:0]        row_eff;
   logic [COL_W-1:0]        col_eff;
   logic                    drain;
   logic                    ignore;
   logic                    take;
   logic                    work;
   logic                    col_last;

   taps_type                taps;
   push_type                push;
   rsp_type                 rsp_data;
   logic [RSP_AW:0]         rsp_level;

   // effective frame size
   always_comb begin
      if (width_ff < WIDTH_REG_W'(2)) begin
         w_m1 = COL_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_m1 = COL_W'(width_ff - WIDTH_REG_W'(1));
      end
      eff_h = (height_ff < HEIGHT_REG_W'(2)) ? ROW_W'(2) : height_ff;
   end

   // room for two results from the item in flight and two from a new one
   assign req_stall = (rsp_level > (RSP_AW+1)'(RSP_DEPTH - 4));

   always_comb begin
      row_eff  = (row_ff > eff_h) ? eff_h : row_ff;
      col_eff  = (col_ff > w_m1) ? '0 : col_ff;
      drain    = (row_eff == eff_h);
      // a drain tick before the frame's last sample is dropped
      ignore   = !drain && (req_type == REQ_DRAIN);
      take     = req_valid && !req_stall;
      work     = take && !ignore;
      col_last = (col_eff == w_m1);

      s1_in.valid     = work;
      s1_in.drain     = drain;
      s1_in.first_row = (row_eff == ROW_W'(1));
      s1_in.emit      = (row_eff != '0);
      s1_in.col_ge1   = (col_eff != '0);
      s1_in.col_is1   = (col_eff == COL_W'(1));
      s1_in.col_last  = col_last;
      s1_in.row_odd   = ~row_eff[0];   // parity of the output row r-1
      s1_in.col_odd   = ~col_eff[0];   // parity of the output column c-1
      s1_in.last_row  = drain;
      s1_in.addr      = col_eff;
      s1_in.px        = req_raw_pixel;

      width_in  = width_ff;
      height_in = height_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (csr_write_en) begin
         if (csr_index == REG_IMAGE_WIDTH) begin
            width_in = csr_write_data[WIDTH_REG_W-1:0];
         end else begin
            height_in = csr_write_data[HEIGHT_REG_W-1:0];
         end
         row_in = '0;
         col_in = '0;
      end else if (work) begin
         if (col_last) begin
            col_in = '0;
            row_in = drain ? '0 : row_eff + 1'b1;
         end else begin
            col_in = col_eff + 1'b1;
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         s1_ff     <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         s1_ff     <= s1_in;
      end
   end

   // line store read at the transfer, write-back in the next cycle
   bbd_line_store u_line_store (
      .clock   (clock),
      .rd_en   (work),
      .rd_addr (col_eff),
      .s1      (s1_ff),
      .taps    (taps)
   );

   bbd_window u_window (
      .clock (clock),
      .reset (reset),
      .s1    (s1_ff),
      .taps  (taps),
      .push  (push)
   );

   bbd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .level     (rsp_level)
   );

   assign rsp_red          = rsp_data.red;
   assign rsp_green        = rsp_data.green;
   assign rsp_blue         = rsp_data.blue;
   assign rsp_end_of_line  = rsp_data.end_of_line;
   assign rsp_end_of_frame = rsp_data.end_of_frame;

   // result queue never overruns
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_level <= (RSP_AW+1)'(RSP_DEPTH))
      else $error("result queue overrun");

   // a csr write restarts the frame
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> (row_ff == '0) && (col_ff == '0))
      else $error("frame not restarted after csr write");

   // the column counter stays inside the effective width
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_m1)
      else $error("column counter beyond width");

   // the right edge of an emitting row yields exactly two results
   a_edge_pair: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && s1_ff.emit && s1_ff.col_last) |-> (push.count == 2'd2))
      else $error("right edge did not yield two results");

endmodule
